/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/core/rsl_pkg.sv */
// Package for the lexer: token kinds, scan modes, widths
package rsl_pkg;
  localparam int LINE_BITS = 16;
  localparam int POS_BITS  = 20;
  localparam int KEY_CHARS = 8;
  localparam int OUT_BITS  = 6 + LINE_BITS + 2 * POS_BITS + 2 + 8;

  localparam logic [5:0] K_IF = 6'd0, K_BANG = 6'd9, K_REF = 6'd10, K_COLON = 6'd11,
    K_ARROW = 6'd12, K_FAT = 6'd13, K_TYPE = 6'd14, K_STRING = 6'd15, K_COMMA = 6'd16,
    K_ID = 6'd17, K_NUM = 6'd18, K_ASSIGN = 6'd19, K_EQ = 6'd20, K_PLUS = 6'd21,
    K_MINUS = 6'd22, K_MULT = 6'd23, K_DIV = 6'd24, K_LT = 6'd25, K_GT = 6'd26,
    K_LPAREN = 6'd27, K_RPAREN = 6'd28, K_LBRACE = 6'd29, K_RBRACE = 6'd30,
    K_SEMI = 6'd31, K_EOF = 6'd32;
  localparam logic [1:0] ERR_NONE = 2'd0, ERR_CHAR = 2'd1, ERR_STR = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_STR, M_COMMENT, M_MINUS, M_EQUAL, M_SLASH
  } mode_t;

  typedef struct packed {
    logic [5:0]           kind;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  len;
    logic [1:0]           err;
    logic [7:0]           bad;
  } tok_t;

  function automatic logic [5:0] kw_kind(input logic [63:0] w,
                                         input logic [POS_BITS-1:0] n);
    logic [5:0] k;
    k = K_ID;
    if (n == POS_BITS'(2) && w[15:0] == "fi") k = 6'd0;
    if (n == POS_BITS'(4) && w[31:0] == "esle") k = 6'd1;
    if (n == POS_BITS'(5) && w[39:0] == "elihw") k = 6'd2;
    if (n == POS_BITS'(7) && w[55:0] == "nltnirp") k = 6'd3;
    if (n == POS_BITS'(2) && w[15:0] == "nf") k = 6'd4;
    if (n == POS_BITS'(3) && w[23:0] == "tel") k = 6'd5;
    if (n == POS_BITS'(3) && w[23:0] == "tum") k = 6'd6;
    if (n == POS_BITS'(5) && w[39:0] == "hctam") k = 6'd7;
    if (n == POS_BITS'(1) && w[7:0] == "_") k = 6'd8;
    if (n == POS_BITS'(3) && (w[23:0] == "23i" || w[23:0] == "23u" || w[23:0] == "23f"
        || w[23:0] == "rts")) k = K_TYPE;
    if (n == POS_BITS'(4) && (w[31:0] == "loob" || w[31:0] == "rahc")) k = K_TYPE;
    return k;
  endfunction
endpackage

/* rtl/core/rust_subset_lexer.sv */
// Top level of the streaming lexer
// One character transfer per cycle while in_tready is high; each item yields zero, one or two token
// transfers. The scan step is combinational; a second token of the same item is
// held in a one-entry side register, so input stalls after such items until that token moves to the output slot.
// Output tdata: kind[5:0], line[21:6], start[41:22], length[61:42],
// error[63:62], bad_char[71:64]; tlast marks the last token of an item.
`include "assert_macros.svh"
module rust_subset_lexer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // ch
  input  logic                         in_tuser,   // is_end
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rsl_pkg::OUT_BITS-1:0] out_tdata,  // kind, line, start, length, error, bad_char
  output logic                         out_tlast
);
  import rsl_pkg::*;

  mode_t                mode_r;
  logic [LINE_BITS-1:0] line_r;
  logic [POS_BITS-1:0]  pos_r, pst_r, plen_r;
  logic [63:0]          win_r;
  logic                 hold_r;
  logic                 v0_r, v1_r, l0_r;
  tok_t                 t0_r, t1_r;

  mode_t                mode_nxt;
  logic [LINE_BITS-1:0] line_nxt;
  logic [POS_BITS-1:0]  pos_nxt, pst_nxt, plen_nxt;
  logic [63:0]          win_nxt;
  logic                 hold_nxt;
  tok_t                 ta, tb;
  logic                 va, vb;
  logic                 acc;

  // skid: output slot t0, pending second slot t1
  assign in_tready = rst_n && !v1_r && (!v0_r || out_tready);
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = v0_r;
  assign out_tdata = {t0_r.bad, t0_r.err, t0_r.len, t0_r.start, t0_r.line, t0_r.kind};
  assign out_tlast = l0_r;

  function automatic logic [POS_BITS-1:0] pinc(input logic [POS_BITS-1:0] v);
    return (v == '1) ? v : v + POS_BITS'(1);
  endfunction

  always_comb begin
    logic [7:0]           c;
    logic                 dig, alp, spc, handled;
    logic [LINE_BITS-1:0] ln;
    tok_t                 tk;
    c = in_tdata;
    dig = c >= "0" && c <= "9";
    alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    spc = c == " " || (c >= 8'd9 && c <= 8'd13);
    ln = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);
    mode_nxt = mode_r; line_nxt = line_r; pos_nxt = pos_r; pst_nxt = pst_r;
    plen_nxt = plen_r; win_nxt = win_r; hold_nxt = hold_r;
    va = 1'b0; vb = 1'b0; handled = 1'b0;
    tk = '{kind: K_ID, line: line_r, start: pst_r, len: plen_r, err: ERR_NONE, bad: 8'd0};
    ta = tk; tb = tk;
    if (in_tuser) begin
      va = 1'b0;
      if (!hold_r) begin
        unique case (mode_r)
          M_STR:   begin va = 1'b1; ta.kind = K_IF; ta.err = ERR_STR; end
          M_NUM:   begin va = 1'b1; ta.kind = K_NUM; end
          M_IDENT: begin
            va = 1'b1;
            ta.kind = (plen_r > POS_BITS'(KEY_CHARS)) ? K_ID : kw_kind(win_r, plen_r);
          end
          M_MINUS: begin va = 1'b1; ta.kind = K_MINUS; ta.len = POS_BITS'(1); end
          M_EQUAL: begin va = 1'b1; ta.kind = K_ASSIGN; ta.len = POS_BITS'(1); end
          M_SLASH: begin va = 1'b1; ta.kind = K_DIV; ta.len = POS_BITS'(1); end
          default: ;
        endcase
      end
      tb = '{kind: K_EOF, line: line_r, start: pos_r, len: '0, err: ERR_NONE, bad: 8'd0};
      vb = 1'b1;
      mode_nxt = M_IDLE; line_nxt = LINE_BITS'(1); pos_nxt = '0; pst_nxt = '0;
      plen_nxt = '0; win_nxt = '0; hold_nxt = 1'b0;
    end else if (!hold_r) begin
      unique case (mode_r)
        M_NUM: if (dig || c == ".") begin plen_nxt = pinc(plen_r); handled = 1'b1; end
        M_IDENT: if (alp || dig || c == "_") begin
          if (plen_r < POS_BITS'(KEY_CHARS)) win_nxt[plen_r[2:0]*8 +: 8] = c;
          plen_nxt = pinc(plen_r); handled = 1'b1;
        end
        M_STR: begin
          plen_nxt = pinc(plen_r); handled = 1'b1;
          if (c == 8'h0a) line_nxt = ln;
          if (c == "\"") begin
            va = 1'b1; ta.kind = K_STRING; ta.len = pinc(plen_r);
            ta.line = (c == 8'h0a) ? ln : line_r; mode_nxt = M_IDLE;
          end
        end
        M_COMMENT: begin
          handled = 1'b1;
          if (c == 8'h0a) begin line_nxt = ln; mode_nxt = M_IDLE; end
        end
        M_MINUS: if (c == ">") begin
          va = 1'b1; ta.kind = K_ARROW; ta.len = POS_BITS'(2); mode_nxt = M_IDLE;
          handled = 1'b1;
        end
        M_EQUAL: if (c == "=" || c == ">") begin
          va = 1'b1; ta.kind = (c == "=") ? K_EQ : K_FAT; ta.len = POS_BITS'(2);
          mode_nxt = M_IDLE; handled = 1'b1;
        end
        M_SLASH: if (c == "/") begin mode_nxt = M_COMMENT; handled = 1'b1; end
        default: ;
      endcase
      if (!handled) begin
        // flush pending token in slot a, then scan the character in slot b
        unique case (mode_r)
          M_NUM:   begin va = 1'b1; ta.kind = K_NUM; end
          M_IDENT: begin
            va = 1'b1;
            ta.kind = (plen_r > POS_BITS'(KEY_CHARS)) ? K_ID : kw_kind(win_r, plen_r);
          end
          M_MINUS: begin va = 1'b1; ta.kind = K_MINUS; ta.len = POS_BITS'(1); end
          M_EQUAL: begin va = 1'b1; ta.kind = K_ASSIGN; ta.len = POS_BITS'(1); end
          M_SLASH: begin va = 1'b1; ta.kind = K_DIV; ta.len = POS_BITS'(1); end
          default: ;
        endcase
        mode_nxt = M_IDLE;
        tb = '{kind: K_ID, line: line_r, start: pos_r, len: POS_BITS'(1), err: ERR_NONE,
               bad: 8'd0};
        if (spc) begin
          if (c == 8'h0a) line_nxt = ln;
        end else if (dig) begin
          mode_nxt = M_NUM; pst_nxt = pos_r; plen_nxt = POS_BITS'(1);
        end else if (alp || c == "_") begin
          mode_nxt = M_IDENT; pst_nxt = pos_r; plen_nxt = POS_BITS'(1);
          win_nxt = {56'd0, c};
        end else begin
          case (c)
            "\"": begin mode_nxt = M_STR; pst_nxt = pos_r; plen_nxt = POS_BITS'(1); end
            "-": begin mode_nxt = M_MINUS; pst_nxt = pos_r; plen_nxt = POS_BITS'(1); end
            "=": begin mode_nxt = M_EQUAL; pst_nxt = pos_r; plen_nxt = POS_BITS'(1); end
            "/": begin mode_nxt = M_SLASH; pst_nxt = pos_r; plen_nxt = POS_BITS'(1); end
            "+": begin vb = 1'b1; tb.kind = K_PLUS; end
            "*": begin vb = 1'b1; tb.kind = K_MULT; end
            "!": begin vb = 1'b1; tb.kind = K_BANG; end
            "&": begin vb = 1'b1; tb.kind = K_REF; end
            ":": begin vb = 1'b1; tb.kind = K_COLON; end
            ",": begin vb = 1'b1; tb.kind = K_COMMA; end
            "<": begin vb = 1'b1; tb.kind = K_LT; end
            ">": begin vb = 1'b1; tb.kind = K_GT; end
            "(": begin vb = 1'b1; tb.kind = K_LPAREN; end
            ")": begin vb = 1'b1; tb.kind = K_RPAREN; end
            "{": begin vb = 1'b1; tb.kind = K_LBRACE; end
            "}": begin vb = 1'b1; tb.kind = K_RBRACE; end
            ";": begin vb = 1'b1; tb.kind = K_SEMI; end
            default: begin
              vb = 1'b1; tb.kind = K_IF; tb.err = ERR_CHAR; tb.bad = c; hold_nxt = 1'b1;
            end
          endcase
        end
      end
      pos_nxt = pinc(pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; line_r <= LINE_BITS'(1); pos_r <= '0; pst_r <= '0; plen_r <= '0;
      win_r <= '0; hold_r <= 1'b0; v0_r <= 1'b0; v1_r <= 1'b0; l0_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt; line_r <= line_nxt; pos_r <= pos_nxt; pst_r <= pst_nxt;
        plen_r <= plen_nxt; win_r <= win_nxt; hold_r <= hold_nxt;
      end
      if (acc && (va || vb)) begin
        v0_r <= 1'b1;
        t0_r <= va ? ta : tb;
        l0_r <= !(va && vb);
        v1_r <= va && vb;
        t1_r <= tb;
      end else if (v0_r && out_tready) begin
        v0_r <= v1_r;
        t0_r <= t1_r;
        l0_r <= 1'b1;
        v1_r <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_no_accept_pending, clk, rst_n, acc && v1_r)
  `ASSERT_IMPL(a_second_last, clk, rst_n, (v0_r && v1_r) |-> !l0_r)
  `ASSERT_IMPL(a_end_resets, clk, rst_n, (acc && in_tuser) |=> (line_r == LINE_BITS'(1) && !hold_r))
endmodule
